@@ src/ddh_pkg.sv @@
// ----------------------------------------------------------------------------
// ddh_pkg: shared types and codes of the distance decay histogram
// operation and status codes, table sizes, controller-datapath command and status
// ----------------------------------------------------------------------------
package ddh_pkg;

  // table sizes, tied to the port widths
  localparam int MAX_REFS = 256;
  localparam int MAX_BINS = 65536;
  localparam int MAX_DIST = 1024;

  localparam logic [2:0] OP_ADD_REF  = 3'd0;
  localparam logic [2:0] OP_OUTLIER  = 3'd1;
  localparam logic [2:0] OP_CONTACT  = 3'd2;
  localparam logic [2:0] OP_PAIRS    = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEGATIVE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,      // idle
    CMD_CLEAR,     // clear one entry of histogram and outlier map
    CMD_LOAD,      // capture input item
    CMD_REF_RD,    // read reference tables
    CMD_OUT_RD,    // read outlier bits of both ends
    CMD_EXEC,      // decide and update (add ref, outlier, contact, read, pair walk start)
    CMD_SUM_RD,    // read distance sum for contact
    CMD_SUM_WR,    // write back saturated sum
    CMD_PR_REF,    // count pairs: read reference entry
    CMD_PR_BIN,    // count pairs: read outlier of bin b
    CMD_PR_DRD,    // count pairs: read outlier of bin b-d and pair count d
    CMD_PR_DWR     // count pairs: write pair count d
  } ddh_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_sum;     // contact passes all checks, update sum
    logic pr_refs_done; // no more references
    logic pr_bin_skip;  // bin is outlier
    logic pr_bins_done; // reference finished
    logic pr_dist_done; // last distance of this bin
  } ddh_stat_t;

endpackage

@@ src/ddh_datapath.sv @@
// ----------------------------------------------------------------------------
// ddh_datapath: tables, outlier map, histogram memories and counters
// executes one command per cycle from the controller
// ----------------------------------------------------------------------------
module ddh_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ddh_pkg::ddh_cmd_t cmd,
  output ddh_pkg::ddh_stat_t stat,
  input  logic              max_distance_we,
  input  logic [9:0]        max_distance_wd,
  input  logic [2:0]        operation,
  input  logic [8:0]        first_ref,
  input  logic [8:0]        second_ref,
  input  logic [15:0]       first_bin,
  input  logic [15:0]       second_bin,
  input  logic [30:0]       contact_count,
  input  logic [15:0]       ref_size,
  input  logic [9:0]        distance_index,
  output logic [1:0]        status,
  output logic              counted,
  output logic [16:0]       assigned_offset,
  output logic [47:0]       distance_sum,
  output logic [31:0]       pair_count
);
  import ddh_pkg::*;

  localparam int RW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int BW = $clog2(MAX_BINS);
  localparam int DW = (MAX_DIST > 1) ? $clog2(MAX_DIST) : 1;
  localparam int CW = $clog2(MAX_BINS + 1); // bin counts and offsets
  localparam int NW = $clog2(MAX_REFS + 1);
  localparam int XW = (BW > DW) ? BW : DW;  // clear sweep index

  logic [CW-1:0] offset_mem [MAX_REFS];
  logic [15:0]   last_mem [MAX_REFS];
  logic          outlier_mem [MAX_BINS];
  logic [47:0]   sum_mem [MAX_DIST];
  logic [31:0]   pair_mem [MAX_DIST];

  logic [NW-1:0] ref_count;
  logic [CW-1:0] total_bins;
  logic [9:0]    max_distance;
  logic [XW:0]   clr;

  // captured item
  logic [2:0]  op_q;
  logic [8:0]  r1_q, r2_q;
  logic [15:0] b1_q, b2_q, size_q;
  logic [30:0] cnt_q;
  logic [9:0]  di_q;

  logic [CW-1:0] off_r;
  logic [15:0]   last_r;
  logic          o1_r, o2_r;
  logic [47:0]   sum_r;
  logic [DW-1:0] dsel;

  // pair walk
  logic [NW-1:0] pr_ref;
  logic [16:0]   pr_b;
  logic [DW:0]   pr_d;
  logic          pr_ob, pr_od;
  logic [31:0]   pr_cnt;

  logic [DW-1:0] dmax;
  logic [10:0]   dlim;
  logic          r1_ok, r2_ok;
  logic [16:0]   diff;
  logic [CW:0]   i1, i2, ib, id;
  logic [CW:0]   fit;

  always_comb begin
    dlim = (11'(max_distance) < 11'(MAX_DIST - 1)) ? 11'(max_distance) : 11'(MAX_DIST - 1);
    dmax = DW'(dlim);
    r1_ok = (r1_q != 9'd0) && ({1'b0, r1_q} <= 10'(ref_count));
    r2_ok = (r2_q != 9'd0) && ({1'b0, r2_q} <= 10'(ref_count));
    diff = {1'b0, b1_q} - {1'b0, b2_q};
    i1 = (CW+1)'(off_r) + (CW+1)'(b1_q);
    i2 = (CW+1)'(off_r) + (CW+1)'(b2_q);
    ib = (CW+1)'(off_r) + (CW+1)'(pr_b);
    id = ib - (CW+1)'(pr_d);
    fit = (CW+1)'(total_bins) + (CW+1)'(size_q) + (CW+1)'(1);
    stat.clear_done   = (clr == (XW+1)'(((MAX_BINS > MAX_DIST) ? MAX_BINS : MAX_DIST) - 1));
    stat.need_sum     = (op_q == OP_CONTACT) && r1_ok && r2_ok && (r1_q == r2_q)
                        && (b1_q <= last_r) && (b2_q <= last_r) && !o1_r && !o2_r
                        && (b2_q <= b1_q) && (diff <= 17'(dlim));
    stat.pr_refs_done = (pr_ref == ref_count) || (pr_ref == NW'(MAX_REFS));
    stat.pr_bins_done = (pr_b == 17'(last_r));
    stat.pr_bin_skip  = pr_ob;
    stat.pr_dist_done = ((DW+1)'(dmax) == pr_d) || (17'(pr_d) == pr_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      total_bins <= '0;
      max_distance <= 10'd1023;
      clr <= '0;
    end else begin
      if (max_distance_we) max_distance <= max_distance_wd;
      case (cmd)
        CMD_CLEAR: begin
          if (clr < (XW+1)'(MAX_BINS)) outlier_mem[clr[BW-1:0]] <= 1'b0;
          if (clr < (XW+1)'(MAX_DIST)) begin
            sum_mem[clr[DW-1:0]] <= '0;
            pair_mem[clr[DW-1:0]] <= '0;
          end
          clr <= clr + 1'b1;
        end
        CMD_LOAD: begin
          op_q <= operation; r1_q <= first_ref; r2_q <= second_ref;
          b1_q <= first_bin; b2_q <= second_bin; cnt_q <= contact_count;
          size_q <= ref_size; di_q <= distance_index;
        end
        CMD_REF_RD: begin
          off_r  <= offset_mem[RW'(r1_q - 9'd1)];
          last_r <= last_mem[RW'(r1_q - 9'd1)];
        end
        CMD_OUT_RD: begin
          o1_r <= (i1 < (CW+1)'(MAX_BINS)) ? outlier_mem[BW'(i1)] : 1'b0;
          o2_r <= (i2 < (CW+1)'(MAX_BINS)) ? outlier_mem[BW'(i2)] : 1'b0;
          dsel <= DW'(diff);
        end
        CMD_EXEC: begin
          status <= ST_OK; counted <= 1'b0; assigned_offset <= '0;
          distance_sum <= '0; pair_count <= '0;
          case (op_q)
            OP_ADD_REF: begin
              if (ref_count >= NW'(MAX_REFS) || fit > (CW+1)'(MAX_BINS)) begin
                status <= ST_FULL;
              end else begin
                assigned_offset <= 17'(total_bins);
                offset_mem[RW'(ref_count)] <= total_bins;
                last_mem[RW'(ref_count)] <= size_q;
                ref_count <= ref_count + 1'b1;
                total_bins <= CW'(fit);
              end
            end
            OP_OUTLIER: begin
              if (!r1_ok || b1_q > last_r) status <= ST_RANGE;
              else if (i1 < (CW+1)'(MAX_BINS)) outlier_mem[BW'(i1)] <= 1'b1;
            end
            OP_CONTACT: begin
              if (!r1_ok || !r2_ok) status <= ST_RANGE;
              else if (r1_q == r2_q) begin
                if (b1_q > last_r || b2_q > last_r) status <= ST_RANGE;
                else if (!o1_r && !o2_r && b2_q > b1_q) status <= ST_NEGATIVE;
                else if (stat.need_sum) counted <= 1'b1;
              end
            end
            OP_PAIRS: pr_ref <= '0; // walk starts at the first reference
            OP_READ: begin
              if (32'(di_q) >= 32'(MAX_DIST)) status <= ST_RANGE;
              else begin
                distance_sum <= sum_mem[DW'(di_q)];
                pair_count <= pair_mem[DW'(di_q)];
              end
            end
            default: status <= ST_RANGE;
          endcase
        end
        CMD_SUM_RD: sum_r <= sum_mem[dsel];
        CMD_SUM_WR: begin
          sum_mem[dsel] <= ((49'(sum_r) + 49'(cnt_q)) > 49'hFFFF_FFFF_FFFF)
                           ? 48'hFFFF_FFFF_FFFF : 48'(sum_r + 48'(cnt_q));
        end
        CMD_PR_REF: begin
          off_r <= offset_mem[RW'(pr_ref)];
          last_r <= last_mem[RW'(pr_ref)];
          pr_ref <= pr_ref + 1'b1;
          pr_b <= '1; // wraps to 0 on first bin step
        end
        CMD_PR_BIN: begin
          pr_b <= pr_b + 1'b1;
          pr_d <= '0;
          pr_ob <= ((CW+1)'(off_r) + (CW+1)'(17'(pr_b + 1'b1)) < (CW+1)'(MAX_BINS))
                   ? outlier_mem[BW'((CW+1)'(off_r) + (CW+1)'(17'(pr_b + 1'b1)))] : 1'b0;
        end
        CMD_PR_DRD: begin
          pr_od <= (id < (CW+1)'(MAX_BINS)) ? outlier_mem[BW'(id)] : 1'b0;
          pr_cnt <= pair_mem[DW'(pr_d)];
        end
        CMD_PR_DWR: begin
          if (!pr_od && pr_cnt != 32'hFFFF_FFFF) pair_mem[DW'(pr_d)] <= pr_cnt + 1'b1;
          pr_d <= pr_d + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ src/ddh_controller.sv @@
// ----------------------------------------------------------------------------
// ddh_controller: sequencer for the distance decay histogram
// steps the datapath through each request and the count-pairs walk
// ----------------------------------------------------------------------------
module ddh_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         operation,
  output ddh_pkg::ddh_cmd_t  cmd,
  input  ddh_pkg::ddh_stat_t stat
);
  import ddh_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REF, S_OUT, S_EXEC, S_SUM_RD, S_SUM_WR,
    S_PR_REF, S_PR_BIN, S_PR_CHK, S_PR_DRD, S_PR_DWR, S_DONE
  } state_t;

  state_t state;
  logic   pairs_q;
  logic   accept;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  always_comb begin
    case (state)
      S_CLEAR:  cmd = CMD_CLEAR;
      S_IDLE:   cmd = accept ? CMD_LOAD : CMD_NONE;
      S_REF:    cmd = CMD_REF_RD;
      S_OUT:    cmd = CMD_OUT_RD;
      S_EXEC:   cmd = CMD_EXEC;
      S_SUM_RD: cmd = CMD_SUM_RD;
      S_SUM_WR: cmd = CMD_SUM_WR;
      S_PR_REF: cmd = stat.pr_refs_done ? CMD_NONE : CMD_PR_REF;
      S_PR_BIN: cmd = CMD_PR_BIN;
      S_PR_DRD: cmd = CMD_PR_DRD;
      S_PR_DWR: cmd = CMD_PR_DWR;
      default:  cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
      pairs_q <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE: if (accept) begin
          state <= S_REF;
          pairs_q <= (operation == OP_PAIRS);
        end
        S_REF: state <= S_OUT;
        S_OUT: state <= S_EXEC;
        S_EXEC: begin
          if (stat.need_sum) state <= S_SUM_RD;
          else if (pairs_q) state <= S_PR_REF;
          else state <= S_DONE;
        end
        S_SUM_RD: state <= S_SUM_WR;
        S_SUM_WR: state <= S_DONE;
        S_PR_REF: state <= stat.pr_refs_done ? S_DONE : S_PR_BIN;
        S_PR_BIN: state <= S_PR_CHK;
        S_PR_CHK: begin
          if (!stat.pr_bin_skip) state <= S_PR_DRD;
          else if (stat.pr_bins_done) state <= S_PR_REF;
          else state <= S_PR_BIN;
        end
        S_PR_DRD: state <= S_PR_DWR;
        S_PR_DWR: begin
          if (!stat.pr_dist_done) state <= S_PR_DRD;
          else if (stat.pr_bins_done) state <= S_PR_REF;
          else state <= S_PR_BIN;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/distance_decay_histogram_top.sv @@
// ----------------------------------------------------------------------------
// distance_decay_histogram_top: contact histogram by bin distance
// request: reference read, outlier read, execute, done; a counted contact adds sum read and write
// count pairs: per reference a table read, per bin an outlier check, per distance a read and a write
// throughput: one request in flight, next request taken as the result leaves
// reset: a clearing pass over the outlier map and histogram memories, stall held high
// ----------------------------------------------------------------------------
module distance_decay_histogram_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [8:0]  first_ref,
  input  logic [8:0]  second_ref,
  input  logic [15:0] first_bin,
  input  logic [15:0] second_bin,
  input  logic [30:0] contact_count,
  input  logic [15:0] ref_size,
  input  logic [9:0]  distance_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        counted,
  output logic [16:0] assigned_offset,
  output logic [47:0] distance_sum,
  output logic [31:0] pair_count,
  // configuration
  input  logic        max_distance_we,
  input  logic [9:0]  max_distance_wd
);
  import ddh_pkg::*;

  ddh_cmd_t  cmd;
  ddh_stat_t stat;

  // sequencer: one request at a time
  ddh_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .operation, .cmd, .stat
  );

  // storage and arithmetic, sizes from the package
  ddh_datapath u_dp (
    .clk, .rst, .cmd, .stat, .max_distance_we, .max_distance_wd,
    .operation, .first_ref, .second_ref, .first_bin, .second_bin,
    .contact_count, .ref_size, .distance_index,
    .status, .counted, .assigned_offset, .distance_sum, .pair_count
  );
endmodule
